### src/sfla_pkg.sv
`default_nettype none

package sfla_pkg;

	localparam int unsigned ADDR_W     = 20;
	localparam int unsigned ARENA_W    = ADDR_W + 1;
	localparam int unsigned REQ_W      = 13;
	localparam int unsigned GRAIN_LOG2 = 4;
	localparam int unsigned SLOT_W     = 16;
	localparam int unsigned SLOT_DEPTH = 1 << SLOT_W;
	localparam int unsigned HDR_CLS_W  = 4;
	localparam int unsigned HDR_W      = HDR_CLS_W + 1;
	localparam int unsigned LINK_W     = ADDR_W + 1;
	// wide enough for the largest class plus header at any legal setting
	localparam int unsigned CALC_W     = 25;

	localparam logic [ARENA_W-1:0] ARENA_LIMIT = ARENA_W'(1) << ADDR_W;
	localparam logic [ARENA_W-1:0] ARENA_RESET = ARENA_W'(1048576);

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_EXHAUSTED    = 2'd1,
		ST_OUTSIDE      = 2'd2,
		ST_ALREADY_FREE = 2'd3
	} status_t;

	typedef struct packed {
		logic capture;
		logic rd_en;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

### src/sfla_ctrl.sv
`default_nettype none

module sfla_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  wire logic           out_stall,
	output sfla_pkg::cmd_t      cmd
);

	import sfla_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_READ = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   accept;
	logic   commit;

	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && (state_q == S_IDLE);
	// finish only when the result slot is empty or drains this cycle
	assign commit    = (state_q == S_EXEC) && (!out_valid_q || !out_stall);
	assign out_valid = out_valid_q;

	assign cmd.capture = accept;
	assign cmd.rd_en   = (state_q == S_READ);
	assign cmd.commit  = commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (commit) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == S_READ)
		else $error("accepted request did not start a memory read");

	a_read_then_exec: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_READ |=> state_q == S_EXEC)
		else $error("memory read not followed by commit stage");

	a_commit_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		commit |=> out_valid_q && state_q == S_IDLE)
		else $error("commit did not present a result");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_EXEC && !commit |=> state_q == S_EXEC && out_valid_q)
		else $error("commit stage left while result slot full");

endmodule

`default_nettype wire

### src/sfla_dp.sv
`default_nettype none

module sfla_dp #(
	parameter int unsigned NUM_CLASSES    = 9,
	parameter int unsigned MIN_CLASS_LOG2 = 4,
	parameter int unsigned HEADER_BYTES   = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire sfla_pkg::cmd_t                 cmd,
	input  wire logic                           cfg_wr_en,
	input  wire logic [sfla_pkg::ARENA_W-1:0]   cfg_wr_data,
	input  wire logic                           opcode,
	input  wire logic [sfla_pkg::REQ_W-1:0]     request_bytes,
	input  wire logic [sfla_pkg::ADDR_W-1:0]    payload_offset,
	output logic [sfla_pkg::ADDR_W-1:0]         block_offset,
	output logic [1:0]                          status
);

	import sfla_pkg::*;

	localparam int unsigned CLS_W = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
	localparam logic [CLS_W-1:0] TOP_CLASS = CLS_W'(NUM_CLASSES - 1);

	logic [HDR_W-1:0]  hdr_mem [SLOT_DEPTH];
	logic [LINK_W-1:0] link_mem [SLOT_DEPTH];

	logic [ADDR_W-1:0]      heads_q [NUM_CLASSES];
	logic [NUM_CLASSES-1:0] present_q;
	logic [ARENA_W-1:0]     carved_q;
	logic [ARENA_W-1:0]     arena_q;

	logic                   op_q;
	logic [CLS_W-1:0]       class_q;
	logic [ADDR_W-1:0]      poff_q;
	logic [HDR_W-1:0]       hdr_rd_q;
	logic [LINK_W-1:0]      link_rd_q;
	logic [ADDR_W-1:0]      block_offset_q;
	status_t                status_q;

	// size class of the incoming request
	logic [4:0]             msb;
	logic                   is_pow2;
	logic [4:0]             ceil_log2;
	logic [4:0]             raw_idx;
	logic [CLS_W-1:0]       req_class;

	always_comb begin
		msb = 5'd0;
		for (int i = 0; i < REQ_W; i++) begin
			if (request_bytes[i]) begin
				msb = 5'(i);
			end
		end
		is_pow2   = ((request_bytes & (request_bytes - REQ_W'(1))) == '0);
		ceil_log2 = msb + {4'd0, !is_pow2};
		raw_idx   = ceil_log2 - 5'(MIN_CLASS_LOG2);
		if ({1'b0, request_bytes} <= ((REQ_W + 1)'(1) << MIN_CLASS_LOG2)) begin
			req_class = '0;
		end else if (raw_idx >= 5'(NUM_CLASSES)) begin
			req_class = TOP_CLASS;
		end else begin
			req_class = CLS_W'(raw_idx);
		end
	end

	// working signals for the read and commit stages
	logic [CLS_W-1:0]   hdr_cls;
	logic [CLS_W-1:0]   sel_cls;
	logic [ADDR_W-1:0]  head_val;
	logic               head_bit;
	logic [ARENA_W-1:0] lim;
	logic [ARENA_W-1:0] room;
	logic [CALC_W-1:0]  need;
	logic               no_room;
	logic [ADDR_W-1:0]  carve_off;
	logic               outside;
	logic [SLOT_W-1:0]  hdr_wr_addr;
	logic [HDR_W-1:0]   hdr_wr_data;
	logic               hdr_wr_en;
	logic               link_wr_en;
	logic [ADDR_W-1:0]  res_off;
	status_t            res_status;

	assign hdr_cls = ({1'b0, hdr_rd_q[HDR_CLS_W-1:0]} >= 5'(NUM_CLASSES)) ?
		TOP_CLASS : CLS_W'(hdr_rd_q[HDR_CLS_W-1:0]);
	// one head read port: free pushes onto the header's class, allocate pops its own
	assign sel_cls  = (op_q == OP_FREE) ? hdr_cls : class_q;
	assign head_val = heads_q[sel_cls];
	assign head_bit = present_q[sel_cls];

	assign lim       = (arena_q > ARENA_LIMIT) ? ARENA_LIMIT : arena_q;
	assign room      = (carved_q < lim) ? (lim - carved_q) : '0;
	assign need      = (CALC_W'(1) << (5'(MIN_CLASS_LOG2) + 5'(class_q)))
		+ CALC_W'(HEADER_BYTES);
	assign no_room   = need > CALC_W'(room);
	assign carve_off = ADDR_W'(carved_q + ARENA_W'(HEADER_BYTES));
	assign outside   = {1'b0, poff_q} >= lim;

	always_comb begin
		res_off     = '0;
		res_status  = ST_OK;
		hdr_wr_en   = 1'b0;
		hdr_wr_addr = poff_q[GRAIN_LOG2 +: SLOT_W];
		hdr_wr_data = {1'b1, HDR_CLS_W'(class_q)};
		link_wr_en  = 1'b0;
		if (op_q == OP_ALLOC) begin
			if (head_bit) begin
				res_off     = head_val;
				hdr_wr_en   = 1'b1;
				hdr_wr_addr = head_val[GRAIN_LOG2 +: SLOT_W];
			end else if (no_room) begin
				res_status = ST_EXHAUSTED;
			end else begin
				res_off     = carve_off;
				hdr_wr_en   = 1'b1;
				hdr_wr_addr = carve_off[GRAIN_LOG2 +: SLOT_W];
			end
		end else begin
			if (outside) begin
				res_status = ST_OUTSIDE;
			end else if (!hdr_rd_q[HDR_W-1]) begin
				res_status = ST_ALREADY_FREE;
			end else begin
				hdr_wr_en   = 1'b1;
				hdr_wr_data = {1'b0, hdr_rd_q[HDR_CLS_W-1:0]};
				link_wr_en  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= opcode;
			class_q <= req_class;
			poff_q  <= payload_offset;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			hdr_rd_q  <= hdr_mem[poff_q[GRAIN_LOG2 +: SLOT_W]];
			link_rd_q <= link_mem[head_val[GRAIN_LOG2 +: SLOT_W]];
		end
		if (cmd.commit && hdr_wr_en) begin
			hdr_mem[hdr_wr_addr] <= hdr_wr_data;
		end
		if (cmd.commit && link_wr_en) begin
			link_mem[poff_q[GRAIN_LOG2 +: SLOT_W]] <= head_bit ? {1'b1, head_val} : '0;
		end
	end

	// list heads: pop follows the link, push takes the freed offset
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			if (op_q == OP_ALLOC && head_bit && link_rd_q[LINK_W-1]) begin
				heads_q[sel_cls] <= link_rd_q[ADDR_W-1:0];
			end else if (op_q == OP_FREE && link_wr_en) begin
				heads_q[sel_cls] <= poff_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			carved_q  <= '0;
		end else if (cmd.commit) begin
			if (op_q == OP_ALLOC) begin
				if (head_bit) begin
					if (!link_rd_q[LINK_W-1]) begin
						present_q[sel_cls] <= 1'b0;
					end
				end else if (!no_room) begin
					carved_q <= ARENA_W'(CALC_W'(carved_q) + need);
				end
			end else if (link_wr_en) begin
				present_q[sel_cls] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			arena_q <= ARENA_RESET;
		end else if (cfg_wr_en) begin
			arena_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			block_offset_q <= res_off;
			status_q       <= res_status;
		end
	end

	assign block_offset = block_offset_q;
	assign status       = status_q;

endmodule

`default_nettype wire

### src/size_class_free_list_allocator.sv
// Channel | Handshake            | Payload
// in      | in_valid / in_stall  | opcode, request_bytes, payload_offset
// out     | out_valid / out_stall| block_offset, status
// cfg     | cfg_wr_en            | cfg_wr_data (arena_size)
//
// Each request goes through accept, a registered read of the header and link
// memories, and commit of list heads, metadata and result.
// A new request is taken once the previous one has committed; the result waits
// in the output register and does not block the next accept.
// Reset empties every class list, zeroes the bump pointer and sets the arena to
// 1048576 bytes; the header and link memories are not cleared.
// While a result is stalled and the next request is ready to commit, hold in
// the commit stage.
`default_nettype none

module size_class_free_list_allocator #(
	parameter int unsigned NUM_CLASSES    = 9,
	parameter int unsigned MIN_CLASS_LOG2 = 4,
	parameter int unsigned HEADER_BYTES   = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [sfla_pkg::ARENA_W-1:0]   cfg_wr_data,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           opcode,
	input  wire logic [sfla_pkg::REQ_W-1:0]     request_bytes,
	input  wire logic [sfla_pkg::ADDR_W-1:0]    payload_offset,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [sfla_pkg::ADDR_W-1:0]         block_offset,
	output logic [1:0]                          status
);

	import sfla_pkg::*;

	cmd_t cmd;

	sfla_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	sfla_dp #(
		.NUM_CLASSES    (NUM_CLASSES),
		.MIN_CLASS_LOG2 (MIN_CLASS_LOG2),
		.HEADER_BYTES   (HEADER_BYTES)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.opcode         (opcode),
		.request_bytes  (request_bytes),
		.payload_offset (payload_offset),
		.block_offset   (block_offset),
		.status         (status)
	);

endmodule

`default_nettype wire
